### rtl/brff_pkg.sv
// Shared types and constants of the rectangle first-fit allocator.
// No dependencies.
package brff_pkg;

  localparam int unsigned MapW = 128;
  localparam int unsigned MapH = 128;
  localparam int unsigned RowAw = $clog2(MapH);
  localparam int unsigned ColAw = $clog2(MapW);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_ALLOC = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture command beat
    logic clr_start;  // begin clearing sweep at row 0
    logic clr_step;   // clear one row, advance
    logic alc_start;  // begin marking at rect_y
    logic alc_step;   // mark one row, advance
    logic fnd_start;  // begin column scan
    logic fnd_step;   // process one row of current column
    logic done;       // present result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic alc_last;
    logic fnd_end;    // search finished (found or exhausted)
  } dp_sts_t;

endpackage

### rtl/brff_ctrl.sv
// Controller state machine of the allocator.
// Depends on brff_pkg.
module brff_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        cmd_i,
  input  brff_pkg::dp_sts_t sts_i,
  output brff_pkg::dp_cmd_t dcmd_o,
  output logic              busy
);
  import brff_pkg::*;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_DISP = 7'b0000100,
    S_CLR  = 7'b0001000,
    S_ALC  = 7'b0010000,
    S_FND  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  cmd_e   cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cmd_q   <= CMD_NONE;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && start) cmd_q <= cmd_e'(cmd_i);
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    dcmd_o  = '0;
    unique case (state_q)
      // sweep the row memory clear after reset, no result beat
      S_INIT: begin
        dcmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          dcmd_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (cmd_q)
          CMD_CLEAR: begin
            dcmd_o.clr_start = 1'b1;
            state_d = S_CLR;
          end
          CMD_FIND: begin
            dcmd_o.fnd_start = 1'b1;
            state_d = S_FND;
          end
          CMD_ALLOC: begin
            dcmd_o.alc_start = 1'b1;
            state_d = S_ALC;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_CLR: begin
        dcmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_DONE;
      end
      S_ALC: begin
        dcmd_o.alc_step = 1'b1;
        if (sts_i.alc_last) state_d = S_DONE;
      end
      S_FND: begin
        if (sts_i.fnd_end) state_d = S_DONE;
        else dcmd_o.fnd_step = 1'b1;
      end
      S_DONE: begin
        dcmd_o.done = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

### rtl/brff_dp.sv
// Datapath: occupancy rows, clear/mark sweeps and the column-major search.
// Depends on brff_pkg.
module brff_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  brff_pkg::dp_cmd_t        dcmd_i,
  output brff_pkg::dp_sts_t        sts_o,
  input  logic [7:0]               width_i,
  input  logic [7:0]               height_i,
  input  logic [6:0]               rect_x_i,
  input  logic [6:0]               rect_y_i,
  input  logic [7:0]               rect_w_i,
  input  logic [7:0]               rect_h_i,
  output logic                     res_valid_o,
  output logic                     found_o,
  output logic [6:0]               place_x_o,
  output logic [6:0]               place_y_o
);
  import brff_pkg::*;

  // row memory: one registered read and one write per cycle
  logic [MapW-1:0] rows_q [MapH];
  logic [MapW-1:0] rd_q;

  logic [6:0] rx_q, ry_q;
  logic [7:0] rw_q, rh_q, w_q, h_q;
  logic [7:0] row_q;     // sweep / scan row counter (can reach 128)
  logic [7:0] row_d;
  logic [7:0] col_q;     // candidate column
  logic [7:0] run_q;     // consecutive free rows ending at row_q-1
  logic       found_q;
  logic [6:0] px_q, py_q;
  logic       fend_q;

  // column mask for find: bits [col, col+rw)
  logic [MapW-1:0] fmask, amask, ones_w, ones_lim;
  logic [8:0]      aend;
  logic [MapW-1:0] cur_row;
  logic            row_free;
  logic [7:0]      run_n;
  logic [8:0]      col_end, h_need;

  assign ones_w  = (rw_q >= 8'(MapW)) ? '1 : ((MapW'(1) << rw_q[ColAw-1:0]) - MapW'(1));
  assign fmask   = ones_w << col_q[ColAw-1:0];
  // alloc columns: [rx, min(rx+rw, width))
  assign aend    = ({2'b0, rx_q} + {1'b0, rw_q} < {1'b0, w_q}) ?
                   ({2'b0, rx_q} + {1'b0, rw_q}) : {1'b0, w_q};
  assign ones_lim = (aend >= 9'(MapW)) ? '1 : ((MapW'(1) << aend[ColAw-1:0]) - MapW'(1));
  assign amask   = ones_lim & ~((MapW'(1) << rx_q) - MapW'(1));
  // read data of row_q, fetched on the edge that loaded row_q
  assign cur_row = rd_q;
  assign row_free = ((cur_row & fmask) == '0);
  assign run_n   = row_free ? run_q + 8'd1 : 8'd0;
  assign col_end = {1'b0, col_q} + {1'b0, rw_q};
  assign h_need  = {1'b0, row_q} + 9'd1;

  // next row counter; also the read address, so rd_q tracks row_q
  always_comb begin
    row_d = row_q;
    if (dcmd_i.clr_start || dcmd_i.fnd_start) begin
      row_d = '0;
    end else if (dcmd_i.alc_start) begin
      row_d = {1'b0, ry_q};
    end else if (dcmd_i.clr_step || dcmd_i.alc_step) begin
      row_d = row_q + 8'd1;
    end else if (dcmd_i.fnd_step && col_end <= {1'b0, w_q} && run_n < rh_q) begin
      if (h_need >= {1'b0, h_q}) row_d = '0;
      else row_d = row_q + 8'd1;
    end
  end

  // row storage: clear sweep and alloc marking
  always_ff @(posedge clk_i) begin
    if (dcmd_i.clr_step) begin
      rows_q[row_q[RowAw-1:0]] <= '0;
    end else if (dcmd_i.alc_step && row_q < h_q && row_q < {1'b0, ry_q} + rh_q
                 && {1'b0, rx_q} < w_q) begin
      rows_q[row_q[RowAw-1:0]] <= cur_row | amask;
    end
    rd_q <= rows_q[row_d[RowAw-1:0]];
  end

  // effective map size
  logic [7:0] we, he;
  assign we = (width_i  > 8'(MapW)) ? 8'(MapW) : width_i;
  assign he = (height_i > 8'(MapH)) ? 8'(MapH) : height_i;

  // sequencing of counters and search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      fend_q  <= 1'b0;
      row_q   <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= dcmd_i.done;
      row_q <= row_d;
      if (dcmd_i.load) begin
        rx_q <= rect_x_i; ry_q <= rect_y_i;
        rw_q <= rect_w_i; rh_q <= rect_h_i;
        w_q  <= we;       h_q  <= he;
        found_q <= 1'b0; px_q <= '0; py_q <= '0;
      end
      if (dcmd_i.fnd_start) begin
        col_q <= '0; run_q <= '0;
        if (rw_q > w_q || rh_q > h_q) begin
          fend_q <= 1'b1;
        end else if (rw_q == 8'd0 || rh_q == 8'd0) begin
          fend_q <= 1'b1; found_q <= 1'b1;
        end else begin
          fend_q <= 1'b0;
        end
      end
      if (dcmd_i.fnd_step) begin
        if (col_end > {1'b0, w_q}) begin
          fend_q <= 1'b1;
        end else if (run_n >= rh_q) begin
          fend_q <= 1'b1; found_q <= 1'b1;
          px_q <= col_q[6:0];
          py_q <= 7'(h_need - {1'b0, rh_q});
        end else if (h_need >= {1'b0, h_q}) begin
          col_q <= col_q + 8'd1; run_q <= '0;
        end else begin
          run_q <= run_n;
        end
      end
    end
  end

  assign sts_o.clr_last = (row_q == 8'(MapH - 1));
  assign sts_o.alc_last = (h_need >= {1'b0, h_q}) ||
                          (h_need >= {1'b0, ry_q} + {1'b0, rh_q});
  assign sts_o.fnd_end  = fend_q;
  assign found_o   = res_valid_o & found_q;
  assign place_x_o = res_valid_o ? px_q : '0;
  assign place_y_o = res_valid_o ? py_q : '0;

endmodule

### rtl/bitmap_rect_first_fit_allocator.sv
// Top level of the rectangle first-fit allocator: config registers,
// controller and datapath. Depends on brff_pkg, brff_ctrl, brff_dp.
//
// A command beat is taken when start is high and busy is low; one result
// beat follows on done, valid for a single cycle, and cannot be stalled.
// After reset the block stays busy while it sweeps the row memory clear.
// The next beat can be taken in the result cycle. Clear sweeps the row
// memory one row per cycle, alloc marks rows from rect_y down to the end of
// the rectangle or of the map, cmd 3 only returns a result beat, and a find
// that is decided by its size alone ends without a scan. Otherwise find walks
// candidate columns left to right and rows top to bottom, one row test per
// cycle, keeping a run count of free rows, and stops early when a place
// turns up. The single registered row read per cycle sets this pace.
module bitmap_rect_first_fit_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd_i,
  input  logic [6:0] rect_x_i,
  input  logic [6:0] rect_y_i,
  input  logic [7:0] rect_w_i,
  input  logic [7:0] rect_h_i,
  output logic       done,
  output logic       found_o,
  output logic [6:0] place_x_o,
  output logic [6:0] place_y_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import brff_pkg::*;

  logic [7:0] map_width_q, map_height_q;
  dp_cmd_t dcmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= 8'd128;
      map_height_q <= 8'd128;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        REG_MAP_HEIGHT: map_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  brff_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .cmd_i,
    .sts_i (sts), .dcmd_o (dcmd), .busy
  );

  brff_dp u_dp (
    .clk_i, .rst_ni, .dcmd_i (dcmd), .sts_o (sts),
    .width_i (map_width_q), .height_i (map_height_q),
    .rect_x_i, .rect_y_i, .rect_w_i, .rect_h_i,
    .res_valid_o (done), .found_o, .place_x_o, .place_y_o
  );

  // a result appears only while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |-> !busy)
    else $error("result beat while busy");
  // a result follows the finishing state
  assert property (@(posedge clk_i) disable iff (!rst_ni) dcmd.done |=> done)
    else $error("missing result beat");
  // found only with a result
  assert property (@(posedge clk_i) disable iff (!rst_ni) found_o |-> done)
    else $error("found without result");

endmodule
